FILE: rtl/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

  // Angle input: Q3.28, pi is the clamp limit
  localparam int unsigned          ANGLE_W    = 32;
  localparam int unsigned          ANGLE_FRAC = 28;
  localparam logic signed [31:0]   PI_Q28     = 32'sd843314857;
  localparam logic signed [31:0]   NEG_PI_Q28 = -32'sd843314857;

  // |angle| after clamping fits 30 bits; its square keeps 56 fraction bits
  localparam int unsigned AMAG_W  = 30;
  localparam int unsigned SQ_W    = 2 * AMAG_W;
  localparam int unsigned SQ_FRAC = 2 * ANGLE_FRAC;

  // Term divisor (2i)(2i+1) stays below 2^12 for up to 24 terms
  localparam int unsigned DIV_W = 12;

  // Integer headroom above the internal fraction bits
  localparam int unsigned MAG_GUARD = 3;   // largest term is x^3/6 < 8
  localparam int unsigned ACC_GUARD = 5;   // signed partial sums stay below 8
  localparam int unsigned N_GUARD   = 8;   // term * x^2 before the divide

  localparam int unsigned SINE_W  = 32;
  localparam int          OUT_ONE = 1073741824;

  typedef struct packed {
    logic valid;
    logic neg;
    logic clamped;
  } tss_ctl_t;

endpackage

FILE: rtl/tss_mul.sv
`timescale 1ns / 1ps

// Two-stage unsigned multiplier: four half-width partial products, then the sum.
module tss_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;

  logic [AL+BL-1:0] pp_ll_q;
  logic [AL+BH-1:0] pp_lh_q;
  logic [AH+BL-1:0] pp_hl_q;
  logic [AH+BH-1:0] pp_hh_q;
  logic [PW-1:0]    p_d, p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= (AL+BL)'(a_i[AL-1:0]) * (AL+BL)'(b_i[BL-1:0]);
      pp_lh_q <= (AL+BH)'(a_i[AL-1:0]) * (AL+BH)'(b_i[BW-1:BL]);
      pp_hl_q <= (AH+BL)'(a_i[AW-1:AL]) * (AH+BL)'(b_i[BL-1:0]);
      pp_hh_q <= (AH+BH)'(a_i[AW-1:AL]) * (AH+BH)'(b_i[BW-1:BL]);
    end
  end

  always_comb begin
    p_d = (PW'(pp_hh_q) << (AL + BL)) + (PW'(pp_lh_q) << BL)
        + (PW'(pp_hl_q) << AL) + PW'(pp_ll_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

FILE: rtl/tss_front.sv
`timescale 1ns / 1ps

// Clamp, sign/magnitude split, x^2 and the first term.
module tss_front import tss_pkg::*; #(
  parameter int unsigned FRAC_BITS = 40
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [ANGLE_W-1:0]                 angle_i,
  output tss_ctl_t                           ctl_o,
  output logic [FRAC_BITS+MAG_GUARD-1:0]     mag_o,
  output logic [SQ_W-1:0]                    sq_o,
  output logic [FRAC_BITS+ACC_GUARD-1:0]     acc_o
);

  localparam int unsigned MAG_W = FRAC_BITS + MAG_GUARD;
  localparam int unsigned ACC_W = FRAC_BITS + ACC_GUARD;

  logic signed [31:0]  angle_s, angle_c;
  logic [31:0]         amag32;
  logic                neg_d, clamped_d;
  logic [AMAG_W-1:0]   amag_q;
  tss_ctl_t            ctl1_q, ctl2_q;
  logic [SQ_W-1:0]     sq_d, sq_q;
  logic [MAG_W-1:0]    mag_d, mag_q;
  logic [ACC_W-1:0]    acc_d, acc_q;

  always_comb begin
    angle_s   = $signed(angle_i);
    clamped_d = 1'b0;
    angle_c   = angle_s;
    if (angle_s > PI_Q28) begin
      angle_c   = PI_Q28;
      clamped_d = 1'b1;
    end else if (angle_s < NEG_PI_Q28) begin
      angle_c   = NEG_PI_Q28;
      clamped_d = 1'b1;
    end
    neg_d  = angle_c[31];
    amag32 = neg_d ? 32'(-angle_c) : 32'(angle_c);
  end

  always_comb begin
    sq_d  = SQ_W'(amag_q) * SQ_W'(amag_q);
    mag_d = MAG_W'(amag_q) << (FRAC_BITS - ANGLE_FRAC);
    acc_d = ctl1_q.neg ? ACC_W'(-ACC_W'(mag_d)) : ACC_W'(mag_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= '{valid: valid_i, neg: neg_d, clamped: clamped_d};
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      amag_q <= amag32[AMAG_W-1:0];
      sq_q   <= sq_d;
      mag_q  <= mag_d;
      acc_q  <= acc_d;
    end
  end

  assign ctl_o = ctl2_q;
  assign mag_o = mag_q;
  assign sq_o  = sq_q;
  assign acc_o = acc_q;

endmodule

FILE: rtl/tss_term.sv
`timescale 1ns / 1ps

// One series term, six stages: term*x^2 (2), floor/ceil to 40 frac bits (1),
// reciprocal multiply for the exact divide by (2i)(2i+1) (2), accumulate (1).
module tss_term import tss_pkg::*; #(
  parameter int unsigned FRAC_BITS = 40,
  parameter int unsigned IDX       = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  tss_ctl_t                       ctl_i,
  input  logic [FRAC_BITS+MAG_GUARD-1:0] mag_i,
  input  logic [SQ_W-1:0]                sq_i,
  input  logic [FRAC_BITS+ACC_GUARD-1:0] acc_i,
  output tss_ctl_t                       ctl_o,
  output logic [FRAC_BITS+MAG_GUARD-1:0] mag_o,
  output logic [SQ_W-1:0]                sq_o,
  output logic [FRAC_BITS+ACC_GUARD-1:0] acc_o
);

  localparam int unsigned MAG_W  = FRAC_BITS + MAG_GUARD;
  localparam int unsigned ACC_W  = FRAC_BITS + ACC_GUARD;
  localparam int unsigned N_W    = FRAC_BITS + N_GUARD;
  localparam int unsigned P1_W   = MAG_W + SQ_W;
  localparam int unsigned Q_W    = P1_W - SQ_FRAC;
  localparam int unsigned SHIFT  = N_W + DIV_W;
  localparam int unsigned R_W    = SHIFT - 1;
  localparam int unsigned P2_W   = N_W + R_W;
  localparam int unsigned DEPTH  = 6;
  localparam int unsigned DIVISOR = (2 * IDX) * (2 * IDX + 1);
  // ceil(2^SHIFT / d): exact floor quotient for every dividend below 2^N_W
  localparam logic [127:0] RECIP_WIDE =
    ((128'd1 << SHIFT) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
  localparam logic [R_W-1:0] RECIP = RECIP_WIDE[R_W-1:0];
  localparam logic           SUB_TERM = IDX % 2 == 1;

  tss_ctl_t         ctl_pipe_q [DEPTH];
  logic [SQ_W-1:0]  sq_pipe_q  [DEPTH];
  logic [ACC_W-1:0] acc_pipe_q [DEPTH-1];

  logic [P1_W-1:0]  p1;
  logic [Q_W-1:0]   q;
  logic             rem;
  logic [N_W-1:0]   n_d, n_q;
  logic [P2_W-1:0]  p2;
  logic [MAG_W-1:0] mag_d, mag_q;
  logic [ACC_W-1:0] acc_d, acc_q;
  logic             sub;

  tss_mul #(.AW(MAG_W), .BW(SQ_W)) u_mul_sq (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (mag_i),
    .b_i   (sq_i),
    .p_o   (p1)
  );

  // negative terms want the ceiling of the magnitude
  always_comb begin
    q   = p1[P1_W-1:SQ_FRAC];
    rem = |p1[SQ_FRAC-1:0];
    n_d = N_W'(q);
    if (ctl_pipe_q[1].neg) begin
      n_d = N_W'(q) + N_W'(rem) + N_W'(DIVISOR - 1);
    end
  end

  tss_mul #(.AW(N_W), .BW(R_W)) u_mul_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (n_q),
    .b_i   (RECIP),
    .p_o   (p2)
  );

  always_comb begin
    mag_d = p2[SHIFT +: MAG_W];
    sub   = SUB_TERM ^ ctl_pipe_q[4].neg;
    acc_d = sub ? acc_pipe_q[4] - ACC_W'(mag_d) : acc_pipe_q[4] + ACC_W'(mag_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        ctl_pipe_q[k] <= '0;
      end
    end else if (en_i) begin
      ctl_pipe_q[0] <= ctl_i;
      for (int k = 1; k < DEPTH; k++) begin
        ctl_pipe_q[k] <= ctl_pipe_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_pipe_q[0]  <= sq_i;
      acc_pipe_q[0] <= acc_i;
      for (int k = 1; k < DEPTH; k++) begin
        sq_pipe_q[k] <= sq_pipe_q[k-1];
      end
      for (int k = 1; k < DEPTH - 1; k++) begin
        acc_pipe_q[k] <= acc_pipe_q[k-1];
      end
      n_q   <= n_d;
      mag_q <= mag_d;
      acc_q <= acc_d;
    end
  end

  assign ctl_o = ctl_pipe_q[DEPTH-1];
  assign sq_o  = sq_pipe_q[DEPTH-1];
  assign mag_o = mag_q;
  assign acc_o = acc_q;

endmodule

FILE: rtl/tss_out.sv
`timescale 1ns / 1ps

// Round half up to Q1.30, saturate, then a two-entry output buffer.
// The pipeline only advances while the skid entry is free.
module tss_out import tss_pkg::*; #(
  parameter int unsigned FRAC_BITS = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tss_ctl_t                       ctl_i,
  input  logic [FRAC_BITS+ACC_GUARD-1:0] acc_i,
  output logic                           adv_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [SINE_W-1:0]              sine_o,
  output logic                           clamped_o
);

  localparam int unsigned ACC_W = FRAC_BITS + ACC_GUARD;
  localparam logic [ACC_W-1:0]        RND_HALF = ACC_W'(1) << (FRAC_BITS - 31);
  localparam logic signed [ACC_W-1:0] POS_ONE  = ACC_W'(OUT_ONE);
  localparam logic signed [ACC_W-1:0] NEG_ONE  = -POS_ONE;

  logic [ACC_W-1:0]        rnd;
  logic signed [ACC_W-1:0] shr;
  logic [SINE_W-1:0]       sine_d, r_sine_q;
  tss_ctl_t                r_ctl_q;

  logic              adv, push, pop;
  logic              out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;
  logic              out_load, skid_load;
  logic [SINE_W-1:0] out_sine_q, skid_sine_q;
  logic              out_clamped_q, skid_clamped_q;

  always_comb begin
    rnd = acc_i + RND_HALF;
    shr = $signed(rnd) >>> (FRAC_BITS - 30);
    if (shr > POS_ONE) begin
      sine_d = SINE_W'(OUT_ONE);
    end else if (shr < NEG_ONE) begin
      sine_d = SINE_W'(-OUT_ONE);
    end else begin
      sine_d = shr[SINE_W-1:0];
    end
  end

  assign adv  = ~skid_valid_q;
  assign push = adv & r_ctl_q.valid;
  assign pop  = out_valid_q & ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        skid_valid_d = 1'b0;
        out_load     = 1'b1;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_d = 1'b1;
        skid_load    = 1'b1;
      end else begin
        out_valid_d = 1'b1;
        out_load    = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_ctl_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        r_ctl_q <= ctl_i;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_sine_q <= sine_d;
    end
    if (skid_load) begin
      skid_sine_q    <= r_sine_q;
      skid_clamped_q <= r_ctl_q.clamped;
    end
    if (out_load) begin
      out_sine_q    <= skid_valid_q ? skid_sine_q : r_sine_q;
      out_clamped_q <= skid_valid_q ? skid_clamped_q : r_ctl_q.clamped;
    end
  end

  assign adv_o     = adv;
  assign valid_o   = out_valid_q;
  assign sine_o    = out_sine_q;
  assign clamped_o = out_clamped_q;

endmodule

FILE: rtl/taylor_series_sine.sv
`timescale 1ns / 1ps

// Taylor-series sine: takes an angle in radians (signed Q3.28) on the input
// stream and returns its sine (signed Q1.30, saturated to +-1.0) with a flag
// in tuser when the angle lay beyond +-pi and was clamped. One angle is taken
// every cycle while the pipeline is not halted. The pipeline is a chain of stages:
// two for the clamp and x^2, six for each term after the first (two
// multiplier stages for term*x^2, one to round to the internal grid, two for
// the reciprocal multiply that divides by (2i)(2i+1), one to accumulate), one
// to round and saturate and one output register. A two-entry output buffer
// holds results while the output is stalled; the whole pipeline halts only
// when it is full.
module taylor_series_sine import tss_pkg::*; #(
  parameter int unsigned TERMS              = 18,
  parameter int unsigned INTERNAL_FRAC_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sine
  output logic [0:0]  m_axis_tuser    // [0] clamped
);

  localparam int unsigned MAG_W = INTERNAL_FRAC_BITS + MAG_GUARD;
  localparam int unsigned ACC_W = INTERNAL_FRAC_BITS + ACC_GUARD;

  logic             adv;
  tss_ctl_t         ctl_w [TERMS];
  logic [MAG_W-1:0] mag_w [TERMS];
  logic [SQ_W-1:0]  sq_w  [TERMS];
  logic [ACC_W-1:0] acc_w [TERMS];

  tss_front #(.FRAC_BITS(INTERNAL_FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .angle_i (s_axis_tdata),
    .ctl_o   (ctl_w[0]),
    .mag_o   (mag_w[0]),
    .sq_o    (sq_w[0]),
    .acc_o   (acc_w[0])
  );

  for (genvar g = 1; g < TERMS; g++) begin : g_term
    tss_term #(.FRAC_BITS(INTERNAL_FRAC_BITS), .IDX(g)) u_term (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl_w[g-1]),
      .mag_i  (mag_w[g-1]),
      .sq_i   (sq_w[g-1]),
      .acc_i  (acc_w[g-1]),
      .ctl_o  (ctl_w[g]),
      .mag_o  (mag_w[g]),
      .sq_o   (sq_w[g]),
      .acc_o  (acc_w[g])
    );
  end

  tss_out #(.FRAC_BITS(INTERNAL_FRAC_BITS)) u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_w[TERMS-1]),
    .acc_i     (acc_w[TERMS-1]),
    .adv_o     (adv),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .sine_o    (m_axis_tdata),
    .clamped_o (m_axis_tuser[0])
  );

  assign s_axis_tready = adv;

endmodule
